// ===== rtl/fcsp_pkg.sv =====
// fcsp_pkg: word types, command codes, bus addresses and register offsets
// for the four-channel sample player. No dependencies.
`default_nettype none
package fcsp_pkg;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_MIX   = 2'd3
  } cmd_code_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] bus_address;
    logic [7:0]  write_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0]         read_byte;
    logic               read_claimed;
    logic signed [15:0] mixed_sample;
  } out_word_t;

  localparam logic [15:0] ADDR_DEVSEL  = 16'hFCFF;
  localparam logic [15:0] ADDR_PAGE_LO = 16'hFCFE;
  localparam logic [15:0] ADDR_PAGE_HI = 16'hFCFD;
  localparam logic [7:0]  WINDOW_HI    = 8'hFD;
  localparam logic [15:0] REG_PAGE     = 16'hFEFC;
  localparam logic [3:0]  REG_BLOCK_HI = 4'h8;
  localparam logic [7:0]  MVOL_RESET   = 8'h3F;
  localparam logic [7:0]  VOL_MASK     = 8'hFC;
  localparam logic [7:0]  UNUSED_READ  = 8'hFF;

  // channel register offsets
  localparam logic [3:0] OFF_SAMPLE  = 4'd0;
  localparam logic [3:0] OFF_BANK    = 4'd1;
  localparam logic [3:0] OFF_ADDR_HI = 4'd2;
  localparam logic [3:0] OFF_ADDR_LO = 4'd3;
  localparam logic [3:0] OFF_PER_HI  = 4'd4;
  localparam logic [3:0] OFF_PER_LO  = 4'd5;
  localparam logic [3:0] OFF_LEN_HI  = 4'd6;
  localparam logic [3:0] OFF_LEN_LO  = 4'd7;
  localparam logic [3:0] OFF_CTRL    = 4'd8;
  localparam logic [3:0] OFF_VOL     = 4'd9;
  localparam logic [3:0] OFF_REP_HI  = 4'd10;
  localparam logic [3:0] OFF_REP_LO  = 4'd11;
  localparam logic [3:0] OFF_PEAK    = 4'd12;
  localparam logic [3:0] OFF_MVOL    = 4'd14;
  localparam logic [3:0] OFF_CHSEL   = 4'd15;

endpackage
`default_nettype wire

// ===== rtl/four_channel_sample_player.sv =====
// four_channel_sample_player: bus decode, channel registers, tick and mix
// sequencer around the sample RAM. Uses fcsp_pkg and fcsp_ram.
//
// port       dir  word        purpose
// cmd        in   in_word_t   bus write, bus read, tick or mix request
// res        out  out_word_t  one result word per command
//
// A bus write or register read has its result word registered when it is taken; a
// sample RAM read passes through S_RDWAIT first. A tick spends one S_TICK step per
// channel plus an S_TCAP step for each channel that fetches a byte through the single
// RAM port; a mix one S_MIX step per channel. After reset the sample RAM is cleared,
// one byte a cycle over all 2**RAM_ADDR_BITS addresses, before the first word is taken.
// cmd_stall is high while a command is in progress or a result waits.
`default_nettype none
module four_channel_sample_player #(
  parameter int RAM_ADDR_BITS = 19,
  parameter int CHANNEL_COUNT = 4,
  parameter int DEVICE_ID     = 208
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cmd_valid,
  output logic                     cmd_stall,
  input  wire fcsp_pkg::in_word_t  cmd,
  output logic                     res_valid,
  input  wire logic                res_stall,
  output fcsp_pkg::out_word_t      res
);
  import fcsp_pkg::*;

  localparam int CH_BITS = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam logic [CH_BITS-1:0] LAST_CH = CH_BITS'(CHANNEL_COUNT - 1);
  localparam logic [RAM_ADDR_BITS-1:0] LAST_ADDR = '1;

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_RDWAIT = 6'b000100,
    S_TICK   = 6'b001000,
    S_TCAP   = 6'b010000,
    S_MIX    = 6'b100000
  } state_t;

  state_t state;
  logic [RAM_ADDR_BITS-1:0] clr_addr;
  logic [CH_BITS-1:0] ch;
  logic [15:0] acc;

  logic [7:0]  device_select;
  logic [15:0] page_register;
  logic [CH_BITS-1:0] selected_channel;
  logic [7:0]  master_volume;

  logic [7:0]  current_sample    [CHANNEL_COUNT];
  logic [7:0]  next_sample       [CHANNEL_COUNT];
  logic [7:0]  start_bank        [CHANNEL_COUNT];
  logic [15:0] start_address     [CHANNEL_COUNT];
  logic [7:0]  period_high_latch [CHANNEL_COUNT];
  logic [15:0] sample_period     [CHANNEL_COUNT];
  logic [15:0] sample_length     [CHANNEL_COUNT];
  logic [15:0] repeat_offset     [CHANNEL_COUNT];
  logic [7:0]  channel_volume    [CHANNEL_COUNT];
  logic [7:0]  peak_level        [CHANNEL_COUNT];
  logic        active_flag       [CHANNEL_COUNT];
  logic        repeat_flag       [CHANNEL_COUNT];
  logic        active_previous   [CHANNEL_COUNT];
  logic [15:0] period_counter    [CHANNEL_COUNT];
  logic [15:0] sample_counter    [CHANNEL_COUNT];

  logic                     ram_we;
  logic [RAM_ADDR_BITS-1:0] ram_addr;
  logic [7:0]               ram_wdata;
  logic [7:0]               ram_rdata;

  // value modulo the channel count, by restoring subtraction
  function automatic logic [CH_BITS-1:0] chan_mod(input logic [7:0] v);
    logic [15:0] r;
    r = {8'd0, v};
    for (int k = 7; k >= 0; k--) begin
      if (r >= (16'(CHANNEL_COUNT) << k)) begin
        r = r - (16'(CHANNEL_COUNT) << k);
      end
    end
    return r[CH_BITS-1:0];
  endfunction

  // command decode
  logic accept, dev_on, is_window, is_regs;
  logic [3:0] off;
  logic [23:0] win_full;
  logic [RAM_ADDR_BITS-1:0] win_addr;
  assign cmd_stall = (state != S_IDLE) || res_valid;
  assign accept    = cmd_valid && !cmd_stall;
  assign dev_on    = device_select == 8'(DEVICE_ID);
  assign is_window = cmd.bus_address[15:8] == WINDOW_HI;
  assign is_regs   = (page_register == REG_PAGE) && (cmd.bus_address[7:4] == REG_BLOCK_HI);
  assign off       = cmd.bus_address[3:0];
  assign win_full  = {page_register, cmd.bus_address[7:0]};
  assign win_addr  = win_full[RAM_ADDR_BITS-1:0];

  // tick channel decisions
  logic [24:0] fetch_full;
  logic [RAM_ADDR_BITS-1:0] fetch_addr;
  logic do_fetch, do_latch;
  assign fetch_full = {1'b0, start_bank[ch], 16'd0} + {9'd0, start_address[ch]}
                    + {9'd0, sample_counter[ch]};
  assign fetch_addr = fetch_full[RAM_ADDR_BITS-1:0];
  assign do_latch   = active_flag[ch] && active_previous[ch] && (period_counter[ch] == 16'd0);
  assign do_fetch   = active_flag[ch] && (!active_previous[ch] || period_counter[ch] == 16'd0);

  // mix datapath for the current channel
  logic signed [14:0] prod;
  logic [14:0] mag_full;
  logic [7:0]  mag;
  logic [15:0] acc_next;
  assign prod     = 15'($signed(current_sample[ch]) * $signed({1'b0, channel_volume[ch][7:2]}));
  assign mag_full = prod[14] ? 15'(-prod) : 15'(prod);
  assign mag      = 8'(mag_full >> 6);
  assign acc_next = acc + 16'(prod);

  // register block read
  logic [7:0] reg_rd;
  always_comb begin
    case (off)
      OFF_SAMPLE:  reg_rd = current_sample[selected_channel];
      OFF_BANK:    reg_rd = start_bank[selected_channel];
      OFF_ADDR_HI: reg_rd = start_address[selected_channel][15:8];
      OFF_ADDR_LO: reg_rd = start_address[selected_channel][7:0];
      OFF_PER_HI:  reg_rd = sample_period[selected_channel][15:8];
      OFF_PER_LO:  reg_rd = sample_period[selected_channel][7:0];
      OFF_LEN_HI:  reg_rd = sample_length[selected_channel][15:8];
      OFF_LEN_LO:  reg_rd = sample_length[selected_channel][7:0];
      OFF_CTRL:    reg_rd = {active_flag[selected_channel], 6'd0, repeat_flag[selected_channel]};
      OFF_VOL:     reg_rd = channel_volume[selected_channel];
      OFF_REP_HI:  reg_rd = repeat_offset[selected_channel][15:8];
      OFF_REP_LO:  reg_rd = repeat_offset[selected_channel][7:0];
      OFF_PEAK:    reg_rd = peak_level[selected_channel];
      OFF_MVOL:    reg_rd = master_volume;
      OFF_CHSEL:   reg_rd = 8'(selected_channel);
      default:     reg_rd = UNUSED_READ;
    endcase
  end

  // result word for commands answered without the RAM
  out_word_t imm_res;
  always_comb begin
    imm_res = '0;
    if (cmd.command == CMD_READ && dev_on) begin
      if (cmd.bus_address == ADDR_DEVSEL) begin
        imm_res.read_byte    = ~device_select;
        imm_res.read_claimed = 1'b1;
      end else if (cmd.bus_address == ADDR_PAGE_LO) begin
        imm_res.read_byte    = page_register[7:0];
        imm_res.read_claimed = 1'b1;
      end else if (cmd.bus_address == ADDR_PAGE_HI) begin
        imm_res.read_byte    = page_register[15:8];
        imm_res.read_claimed = 1'b1;
      end else if (is_window && is_regs) begin
        imm_res.read_byte    = reg_rd;
        imm_res.read_claimed = 1'b1;
      end
    end
  end

  // sample RAM port select
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = win_addr;
    ram_wdata = cmd.write_byte;
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_addr;
        ram_wdata = 8'd0;
      end
      S_IDLE: begin
        ram_we = accept && (cmd.command == CMD_WRITE) && (cmd.bus_address != ADDR_DEVSEL)
               && dev_on && is_window && !is_regs;
      end
      S_TICK: begin
        ram_addr = fetch_addr;
      end
      default: ;
    endcase
  end

  fcsp_ram #(.WIDTH(8), .DEPTH(2 ** RAM_ADDR_BITS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // sequencer and state
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_CLEAR;
      clr_addr         <= '0;
      ch               <= '0;
      acc              <= 16'd0;
      res_valid        <= 1'b0;
      device_select    <= 8'd0;
      page_register    <= 16'd0;
      selected_channel <= '0;
      master_volume    <= MVOL_RESET;
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        current_sample[i]    <= 8'd0;
        next_sample[i]       <= 8'd0;
        start_bank[i]        <= 8'd0;
        start_address[i]     <= 16'd0;
        period_high_latch[i] <= 8'd0;
        sample_period[i]     <= 16'd0;
        sample_length[i]     <= 16'd0;
        repeat_offset[i]     <= 16'd0;
        channel_volume[i]    <= 8'd0;
        peak_level[i]        <= 8'd0;
        active_flag[i]       <= 1'b0;
        repeat_flag[i]       <= 1'b0;
        active_previous[i]   <= 1'b0;
        period_counter[i]    <= 16'd0;
        sample_counter[i]    <= 16'd0;
      end
    end else begin
      if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      case (state)
        // sweep the sample RAM to zero
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST_ADDR) begin
            state <= S_IDLE;
          end
        end
        // take one command word
        S_IDLE: begin
          if (accept) begin
            res <= imm_res;
            case (cmd.command)
              CMD_WRITE: begin
                res_valid <= 1'b1;
                if (cmd.bus_address == ADDR_DEVSEL) begin
                  device_select <= cmd.write_byte;
                end else if (dev_on) begin
                  if (cmd.bus_address == ADDR_PAGE_LO) begin
                    page_register[7:0] <= cmd.write_byte;
                  end else if (cmd.bus_address == ADDR_PAGE_HI) begin
                    page_register[15:8] <= cmd.write_byte;
                  end else if (is_window && is_regs) begin
                    case (off)
                      OFF_SAMPLE:  current_sample[selected_channel] <= cmd.write_byte;
                      OFF_BANK:    start_bank[selected_channel] <= cmd.write_byte;
                      OFF_ADDR_HI: start_address[selected_channel][15:8] <= cmd.write_byte;
                      OFF_ADDR_LO: start_address[selected_channel][7:0] <= cmd.write_byte;
                      OFF_PER_HI:  period_high_latch[selected_channel] <= cmd.write_byte;
                      OFF_PER_LO:  sample_period[selected_channel] <=
                                     {period_high_latch[selected_channel], cmd.write_byte};
                      OFF_LEN_HI:  sample_length[selected_channel][15:8] <= cmd.write_byte;
                      OFF_LEN_LO:  sample_length[selected_channel][7:0] <= cmd.write_byte;
                      OFF_CTRL: begin
                        active_flag[selected_channel]    <= cmd.write_byte[7];
                        repeat_flag[selected_channel]    <= cmd.write_byte[0];
                        sample_counter[selected_channel] <= 16'd0;
                      end
                      OFF_VOL:     channel_volume[selected_channel] <= cmd.write_byte & VOL_MASK;
                      OFF_REP_HI:  repeat_offset[selected_channel][15:8] <= cmd.write_byte;
                      OFF_REP_LO:  repeat_offset[selected_channel][7:0] <= cmd.write_byte;
                      OFF_PEAK:    peak_level[selected_channel] <= 8'd0;
                      OFF_MVOL:    master_volume <= cmd.write_byte & VOL_MASK;
                      OFF_CHSEL:   selected_channel <= chan_mod(cmd.write_byte);
                      default: ;
                    endcase
                  end
                end
              end
              CMD_READ: begin
                if (dev_on && is_window && !is_regs) begin
                  state <= S_RDWAIT;
                end else begin
                  res_valid <= 1'b1;
                end
              end
              CMD_TICK: begin
                ch    <= '0;
                state <= S_TICK;
              end
              default: begin
                ch    <= '0;
                acc   <= 16'd0;
                state <= S_MIX;
              end
            endcase
          end
        end
        // sample RAM byte for a bus read
        S_RDWAIT: begin
          res.read_byte    <= ram_rdata;
          res.read_claimed <= 1'b1;
          res_valid        <= 1'b1;
          state            <= S_IDLE;
        end
        // one channel of a tick; a fetch reads the RAM this cycle
        S_TICK: begin
          if (!active_flag[ch]) begin
            period_counter[ch]  <= 16'd0;
            active_previous[ch] <= 1'b0;
          end else if (do_fetch) begin
            if (do_latch) begin
              current_sample[ch] <= next_sample[ch];
            end
            period_counter[ch] <= sample_period[ch];
            if (sample_counter[ch] == sample_length[ch]) begin
              if (repeat_flag[ch]) begin
                sample_counter[ch]  <= repeat_offset[ch];
                active_previous[ch] <= 1'b1;
              end else begin
                sample_counter[ch]  <= 16'd0;
                active_flag[ch]     <= 1'b0;
                active_previous[ch] <= 1'b0;
              end
            end else begin
              sample_counter[ch]  <= sample_counter[ch] + 16'd1;
              active_previous[ch] <= 1'b1;
            end
          end else begin
            period_counter[ch] <= period_counter[ch] - 16'd1;
          end
          if (do_fetch) begin
            state <= S_TCAP;
          end else if (ch == LAST_CH) begin
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end else begin
            ch <= ch + 1'b1;
          end
        end
        // store the fetched byte as the channel's next sample
        S_TCAP: begin
          next_sample[ch] <= ram_rdata;
          if (ch == LAST_CH) begin
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end else begin
            ch    <= ch + 1'b1;
            state <= S_TICK;
          end
        end
        // one channel of the mix per cycle
        S_MIX: begin
          acc <= acc_next;
          if (mag > peak_level[ch]) begin
            peak_level[ch] <= mag;
          end
          if (ch == LAST_CH) begin
            res.mixed_sample <= acc_next;
            res_valid        <= 1'b1;
            state            <= S_IDLE;
          end else begin
            ch <= ch + 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/fcsp_ram.sv =====
// fcsp_ram: generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none
module fcsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // read first port, read data registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ===== tb/sv/four_channel_sample_player_checker.sv =====
// four_channel_sample_player_checker: watches the command and result channels,
// predicts every result word of the sample player and compares. Uses fcsp_pkg.
`default_nettype none
module four_channel_sample_player_checker #(
  parameter int RAM_ADDR_BITS = 19,
  parameter int CHANNEL_COUNT = 4,
  parameter int DEVICE_ID     = 208
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cmd_valid,
  input  wire logic                cmd_stall,
  input  wire fcsp_pkg::in_word_t  cmd,
  input  wire logic                res_valid,
  input  wire logic                res_stall,
  input  wire fcsp_pkg::out_word_t res,
  output int                       errors,
  output int                       pending
);
  import fcsp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RAM_BYTES = 1 << RAM_ADDR_BITS;
  localparam logic [31:0] RAM_MASK = 32'(RAM_BYTES - 1);

  // shadow state of the player
  bit [7:0]  devsel;
  bit [15:0] page;
  bit [7:0]  chsel;
  bit [7:0]  mvol;
  bit [7:0]  ram [RAM_BYTES];
  bit [7:0]  cur [CHANNEL_COUNT];
  bit [7:0]  nxt [CHANNEL_COUNT];
  bit [7:0]  bank [CHANNEL_COUNT];
  bit [15:0] start [CHANNEL_COUNT];
  bit [7:0]  per_latch [CHANNEL_COUNT];
  bit [15:0] period [CHANNEL_COUNT];
  bit [15:0] len [CHANNEL_COUNT];
  bit [15:0] rep [CHANNEL_COUNT];
  bit [7:0]  vol [CHANNEL_COUNT];
  bit [7:0]  peak [CHANNEL_COUNT];
  bit        active [CHANNEL_COUNT];
  bit        looping [CHANNEL_COUNT];
  bit        was_active [CHANNEL_COUNT];
  bit [15:0] per_cnt [CHANNEL_COUNT];
  bit [15:0] pos [CHANNEL_COUNT];

  out_word_t expected_words [$];

  function automatic bit [31:0] window_index(bit [7:0] low);
    return (({16'b0, page} << 8) + low) & RAM_MASK;
  endfunction

  function automatic bit in_regs(bit [15:0] a);
    return page == REG_PAGE && a[7:4] == REG_BLOCK_HI;
  endfunction

  function automatic void fetch_sample(int c);
    bit [31:0] a;
    a = ({24'b0, bank[c]} << 16) + start[c] + pos[c];
    nxt[c] = ram[a & RAM_MASK];
    if (pos[c] == len[c]) begin
      if (looping[c]) begin
        pos[c] = rep[c];
      end else begin
        active[c] = 0;
        pos[c] = '0;
      end
    end else begin
      pos[c] = pos[c] + 16'd1;
    end
  endfunction

  function automatic void write_reg(bit [3:0] off, bit [7:0] v);
    int c;
    c = chsel % CHANNEL_COUNT;
    case (off)
      OFF_SAMPLE:  cur[c] = v;
      OFF_BANK:    bank[c] = v;
      OFF_ADDR_HI: start[c][15:8] = v;
      OFF_ADDR_LO: start[c][7:0] = v;
      OFF_PER_HI:  per_latch[c] = v;
      OFF_PER_LO:  period[c] = {per_latch[c], v};
      OFF_LEN_HI:  len[c][15:8] = v;
      OFF_LEN_LO:  len[c][7:0] = v;
      OFF_CTRL: begin
        active[c] = v[7];
        looping[c] = v[0];
        pos[c] = '0;
      end
      OFF_VOL:     vol[c] = v & VOL_MASK;
      OFF_REP_HI:  rep[c][15:8] = v;
      OFF_REP_LO:  rep[c][7:0] = v;
      OFF_PEAK:    peak[c] = '0;
      OFF_MVOL:    mvol = v & VOL_MASK;
      OFF_CHSEL:   chsel = 8'(v % CHANNEL_COUNT);
      default: ;
    endcase
  endfunction

  function automatic bit [7:0] read_reg(bit [3:0] off);
    int c;
    c = chsel % CHANNEL_COUNT;
    case (off)
      OFF_SAMPLE:  return cur[c];
      OFF_BANK:    return bank[c];
      OFF_ADDR_HI: return start[c][15:8];
      OFF_ADDR_LO: return start[c][7:0];
      OFF_PER_HI:  return period[c][15:8];
      OFF_PER_LO:  return period[c][7:0];
      OFF_LEN_HI:  return len[c][15:8];
      OFF_LEN_LO:  return len[c][7:0];
      OFF_CTRL:    return {active[c], 6'b0, looping[c]};
      OFF_VOL:     return vol[c];
      OFF_REP_HI:  return rep[c][15:8];
      OFF_REP_LO:  return rep[c][7:0];
      OFF_PEAK:    return peak[c];
      OFF_MVOL:    return mvol;
      OFF_CHSEL:   return chsel;
      default:     return UNUSED_READ;
    endcase
  endfunction

  // one tick of every channel
  function automatic void tick_channels();
    for (int c = 0; c < CHANNEL_COUNT; c++) begin
      if (!active[c]) begin
        per_cnt[c] = '0;
      end else if (!was_active[c]) begin
        fetch_sample(c);
        per_cnt[c] = period[c];
      end else if (per_cnt[c] == 0) begin
        cur[c] = nxt[c];
        fetch_sample(c);
        per_cnt[c] = period[c];
      end else begin
        per_cnt[c] = per_cnt[c] - 16'd1;
      end
      was_active[c] = active[c];
    end
  endfunction

  // wrapping sum of sample times volume, peaks tracked on the way
  function automatic bit [15:0] mix_channels();
    int s, prod, mag;
    bit [15:0] sum;
    sum = '0;
    for (int c = 0; c < CHANNEL_COUNT; c++) begin
      s = $signed(cur[c]);
      prod = s * int'(vol[c] >> 2);
      mag = (prod < 0 ? -prod : prod) >>> 6;
      sum = sum + prod[15:0];
      if (mag > int'(peak[c])) peak[c] = mag[7:0];
    end
    return sum;
  endfunction

  function automatic out_word_t predict_word(in_word_t w);
    out_word_t r;
    bit [15:0] a;
    r = '0;
    a = w.bus_address;
    case (cmd_code_t'(w.command))
      CMD_WRITE: begin
        if (a == ADDR_DEVSEL) devsel = w.write_byte;
        else if (devsel == DEVICE_ID) begin
          if (a == ADDR_PAGE_LO) page[7:0] = w.write_byte;
          else if (a == ADDR_PAGE_HI) page[15:8] = w.write_byte;
          else if (a[15:8] == WINDOW_HI) begin
            if (in_regs(a)) write_reg(a[3:0], w.write_byte);
            else ram[window_index(a[7:0])] = w.write_byte;
          end
        end
      end
      CMD_READ: begin
        if (devsel == DEVICE_ID) begin
          r.read_claimed = 1;
          if (a == ADDR_DEVSEL) r.read_byte = ~devsel;
          else if (a == ADDR_PAGE_LO) r.read_byte = page[7:0];
          else if (a == ADDR_PAGE_HI) r.read_byte = page[15:8];
          else if (a[15:8] == WINDOW_HI) begin
            if (in_regs(a)) r.read_byte = read_reg(a[3:0]);
            else r.read_byte = ram[window_index(a[7:0])];
          end else r.read_claimed = 0;
        end
      end
      CMD_TICK: tick_channels();
      default: r.mixed_sample = mix_channels();
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    out_word_t e;
    if (rst) begin
      errors = 0;
      devsel = '0;
      page = '0;
      chsel = '0;
      mvol = MVOL_RESET;
      for (int c = 0; c < CHANNEL_COUNT; c++) begin
        cur[c] = '0; nxt[c] = '0; bank[c] = '0; start[c] = '0;
        per_latch[c] = '0; period[c] = '0; len[c] = '0; rep[c] = '0;
        vol[c] = '0; peak[c] = '0; active[c] = 0; looping[c] = 0;
        was_active[c] = 0; per_cnt[c] = '0; pos[c] = '0;
      end
      expected_words.delete();
    end else begin
      // compare the result word with the oldest prediction
      if (res_valid && !res_stall) begin
        if (expected_words.size() == 0) begin
          $error("result word with nothing expected");
          errors++;
        end else begin
          e = expected_words.pop_front();
          if (res.read_byte !== e.read_byte) begin
            $error("read_byte expected %0h actual %0h", e.read_byte, res.read_byte);
            errors++;
          end
          if (res.read_claimed !== e.read_claimed) begin
            $error("read_claimed expected %0b actual %0b", e.read_claimed, res.read_claimed);
            errors++;
          end
          if (res.mixed_sample !== e.mixed_sample) begin
            $error("mixed_sample expected %0d actual %0d", e.mixed_sample,
                   res.mixed_sample);
            errors++;
          end
        end
      end
      if (cmd_valid && !cmd_stall) expected_words.push_back(predict_word(cmd));
    end
    pending = expected_words.size();
  end
endmodule
`default_nettype wire

// ===== tb/sv/four_channel_sample_player_tb.sv =====
// four_channel_sample_player_tb: clock, reset, command stimulus and result
// stalls for the sample player; uses fcsp_pkg and four_channel_sample_player_checker.
`default_nettype none
module four_channel_sample_player_tb;
  import fcsp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEV = 208;
  localparam int IDLE_LIMIT = 1500000;
  localparam int WORD_TARGET = 1850;

  logic clk = 0;
  logic rst = 1;
  logic cmd_valid = 0;
  logic cmd_stall;
  in_word_t cmd = '0;
  logic res_valid;
  logic res_stall = 0;
  out_word_t res;
  int errors, pending;
  int words_sent = 0;
  int idle_cycles = 0;
  bit gaps_on = 1;
  bit hold_req = 0;
  bit hold_done = 0;

  always #2 clk = ~clk;

  four_channel_sample_player dut (
    .clk(clk), .rst(rst), .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
    .res_valid(res_valid), .res_stall(res_stall), .res(res)
  );

  four_channel_sample_player_checker #(.DEVICE_ID(DEV)) u_checker (
    .clk(clk), .rst(rst), .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
    .res_valid(res_valid), .res_stall(res_stall), .res(res),
    .errors(errors), .pending(pending)
  );

  // watchdog on cycles with no word moving either way
  always @(posedge clk) begin
    if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      res_stall <= 1;
      repeat (400) @(negedge clk);
      hold_req = 0;
    end
    res_stall <= gaps_on && ($urandom_range(99) < 6);
  end

  task automatic put(cmd_code_t c, logic [15:0] a, logic [7:0] d);
    if (gaps_on && $urandom_range(99) < 6) begin
      cmd_valid <= 0;
      repeat ($urandom_range(3, 1)) @(negedge clk);
    end
    cmd <= '{command: c, bus_address: a, write_byte: d};
    cmd_valid <= 1;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    @(negedge clk);
    words_sent++;
  endtask

  task automatic reg_wr(logic [3:0] off, logic [7:0] v);
    put(CMD_WRITE, {WINDOW_HI, REG_BLOCK_HI, off}, v);
  endtask

  task automatic reg_rd(logic [3:0] off);
    put(CMD_READ, {WINDOW_HI, REG_BLOCK_HI, off}, 8'($urandom));
  endtask

  task automatic set_page(logic [15:0] p);
    put(CMD_WRITE, ADDR_PAGE_LO, p[7:0]);
    put(CMD_WRITE, ADDR_PAGE_HI, p[15:8]);
  endtask

  function automatic logic [15:0] small16();
    return $urandom_range(9) == 0 ? 16'($urandom) : 16'($urandom_range(12));
  endfunction

  // program one channel with random content, mostly short samples
  task automatic program_channel();
    logic [15:0] v;
    reg_wr(OFF_CHSEL, 8'($urandom));
    if ($urandom_range(1)) reg_wr(OFF_BANK, $urandom_range(3) == 0 ? 8'($urandom) : 8'd0);
    v = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(40));
    reg_wr(OFF_ADDR_HI, v[15:8]);
    reg_wr(OFF_ADDR_LO, v[7:0]);
    v = $urandom_range(7) == 0 ? 16'($urandom) : 16'($urandom_range(3));
    reg_wr(OFF_PER_HI, v[15:8]);
    reg_wr(OFF_PER_LO, v[7:0]);
    v = small16();
    reg_wr(OFF_LEN_HI, v[15:8]);
    reg_wr(OFF_LEN_LO, v[7:0]);
    v = small16();
    reg_wr(OFF_REP_HI, v[15:8]);
    reg_wr(OFF_REP_LO, v[7:0]);
    reg_wr(OFF_VOL, 8'($urandom));
    reg_wr(OFF_CTRL, {$urandom_range(3) != 0, 6'($urandom), 1'($urandom)});
  endtask

  initial begin
    int pick;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: unselected device, selection, page, registers, mix, ticks
    put(CMD_READ, ADDR_DEVSEL, 8'h00);
    put(CMD_WRITE, ADDR_PAGE_LO, 8'hFC);
    put(CMD_WRITE, ADDR_DEVSEL, 8'(DEV));
    put(CMD_READ, ADDR_DEVSEL, 8'h00);
    put(CMD_READ, 16'h1234, 8'hFF);
    put(CMD_WRITE, 16'hFD00, 8'h7F);
    put(CMD_WRITE, 16'hFDFF, 8'h80);
    set_page(REG_PAGE);
    put(CMD_READ, ADDR_PAGE_HI, 8'h00);
    reg_wr(4'd13, 8'hFF);
    reg_rd(4'd13);
    reg_wr(OFF_CHSEL, 8'hFF);
    reg_rd(OFF_CHSEL);
    reg_wr(OFF_MVOL, 8'hFF);
    reg_rd(OFF_MVOL);
    reg_wr(OFF_SAMPLE, 8'h80);
    reg_wr(OFF_VOL, 8'hFF);
    put(CMD_MIX, 16'hFFFF, 8'h00);
    reg_rd(OFF_PEAK);
    reg_wr(OFF_PEAK, 8'h00);
    reg_wr(OFF_CTRL, 8'h81);
    put(CMD_TICK, 16'h0000, 8'h00);
    put(CMD_TICK, 16'h0000, 8'h00);
    reg_rd(OFF_SAMPLE);

    // random sequences, mostly well formed
    while (words_sent < WORD_TARGET) begin
      if (!hold_done && words_sent > 400) begin
        hold_req = 1;
        hold_done = 1;
      end
      gaps_on = !(words_sent > 900 && words_sent < 1200);
      if ($urandom_range(9) != 0) put(CMD_WRITE, ADDR_DEVSEL, 8'(DEV));
      pick = $urandom_range(99);
      if (pick < 45) begin
        set_page(REG_PAGE);
        program_channel();
        repeat ($urandom_range(12, 2)) begin
          put(cmd_code_t'($urandom_range(3) == 0 ? CMD_MIX : CMD_TICK), 16'($urandom), 8'($urandom));
        end
        repeat ($urandom_range(4)) reg_rd(4'($urandom));
      end else if (pick < 65) begin
        set_page($urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(3)));
        repeat ($urandom_range(8, 1)) put(CMD_WRITE, {WINDOW_HI, 8'($urandom_range(48))}, 8'($urandom));
        repeat ($urandom_range(3)) put(CMD_READ, {WINDOW_HI, 8'($urandom)}, 8'($urandom));
        put(CMD_READ, ADDR_PAGE_LO, 8'($urandom));
      end else if (pick < 85) begin
        repeat ($urandom_range(16, 4)) put(cmd_code_t'($urandom_range(3, 1)), 16'($urandom), 8'($urandom));
      end else begin
        repeat ($urandom_range(4, 1)) begin
          if ($urandom_range(1)) put(cmd_code_t'($urandom_range(3)), 16'($urandom), 8'($urandom));
          else put(cmd_code_t'($urandom_range(1)), {8'hFC + 8'($urandom_range(1)), 8'($urandom)}, 8'($urandom));
        end
      end
    end
    cmd_valid <= 0;
    gaps_on = 1;

    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/fcsp_pkg.sv
rtl/fcsp_ram.sv
rtl/four_channel_sample_player.sv
tb/sv/four_channel_sample_player_checker.sv
tb/sv/four_channel_sample_player_tb.sv
